@@ sv/rcct_pkg.sv @@
// ----------------------------------------------------------------------------
// rcct_pkg - shared types and constants of the routing congestion cost table
// Request and result payloads, decoded job record, command and status codes.
// ----------------------------------------------------------------------------
package rcct_pkg;

  localparam int COST_W    = 32;            // Q(32-F).F cost and factor words
  localparam int OCC_W     = 10;            // stored occupancy
  localparam int CAP_W     = 8;             // stored capacity
  localparam int NODE_W    = 12;            // node index on the ports
  localparam int DELTA_W   = 8;             // signed occupancy change
  localparam int OVER_W    = OCC_W + 1;     // occupancy + 1 - capacity, up to 1024
  localparam int PROD_W    = OVER_W + COST_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int JOBQ_DEPTH = 2;            // front-to-back queue
  localparam int RSPQ_DEPTH = 2;            // result queue

  localparam logic [OCC_W-1:0]  OCC_MAX   = '1;
  localparam logic [COST_W-1:0] COST_MAX  = '1;
  localparam logic [COST_W-1:0] PF_RESET  = 32'h0000_8000;
  localparam logic [COST_W-1:0] HF_RESET  = 32'h0001_0000;

  // Command codes on the request port
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OCC_ZERO = 2'd1,
    ST_OCC_SAT  = 2'd2,
    ST_COST_SAT = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESENT_FACTOR = 1'b0,
    REG_HISTORY_FACTOR = 1'b1
  } cfg_reg_t;

  // Job class decided by the front end
  typedef enum logic [2:0] {
    JOB_LOAD,
    JOB_UPDATE,
    JOB_SWEEP,
    JOB_PEEK,      // unused command: report the entry as stored
    JOB_NULL       // node out of range: report zeros, table untouched
  } kind_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [NODE_W-1:0]         node_index;
    logic signed [DELTA_W-1:0] occ_delta;
    logic [CAP_W-1:0]          capacity_value;
    logic                      path_last;
  } in_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] out_node;
    logic [OCC_W-1:0]  occupancy;
    logic [COST_W-1:0] present_cost;
    logic [COST_W-1:0] history_cost;
    logic [1:0]        status;
    logic              out_last;
  } out_rsp_t;

  typedef struct packed {
    kind_t                     kind;
    logic [NODE_W-1:0]         node_index;
    logic signed [DELTA_W-1:0] occ_delta;
    logic [CAP_W-1:0]          capacity_value;
    logic                      path_last;
  } job_t;

endpackage

@@ sv/routing_congestion_cost_table.sv @@
// ----------------------------------------------------------------------------
// routing_congestion_cost_table - per-node congestion cost table
// Negotiated-congestion router table: occupancy, present and history costs.
// ----------------------------------------------------------------------------
// Each request passes the table engine in order: it reads the node entry, does
// the occupancy update and the factor multiplications, then the saturating
// sums and write-back. Due to the single-ported table and this read-modify-write
// sequence, one request is finished before the next is taken. A
// two-entry queue on each side lets requests and results be moved while the
// engine works. The table has no reset; load every node before using it.
// Configuration may be written only while no request is in flight.
// ----------------------------------------------------------------------------
module routing_congestion_cost_table
  import rcct_pkg::*;
#(
  parameter int NODE_COUNT     = 4096,
  parameter int COST_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_req_t              in_req,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_rsp_t             out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_wdata
);

  logic [COST_W-1:0] present_factor_r, history_factor_r;
  job_t              job;
  logic              job_empty, job_pop;
  logic              rsp_full, rsp_push;
  out_rsp_t          rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_factor_r <= PF_RESET;
      history_factor_r <= HF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESENT_FACTOR: present_factor_r <= cfg_wdata;
        REG_HISTORY_FACTOR: history_factor_r <= cfg_wdata;
        default:            present_factor_r <= present_factor_r;
      endcase
    end
  end

  rcct_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_req    (in_req),
    .in_full   (in_full),
    .job_pop   (job_pop),
    .job       (job),
    .job_empty (job_empty)
  );

  rcct_back #(
    .NODE_COUNT     (NODE_COUNT),
    .COST_FRAC_BITS (COST_FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (job),
    .job_empty      (job_empty),
    .job_pop        (job_pop),
    .present_factor (present_factor_r),
    .history_factor (history_factor_r),
    .out_full       (rsp_full),
    .out_push       (rsp_push),
    .out_rsp        (rsp)
  );

  // Result queue
  rcct_fifo #(
    .WIDTH ($bits(out_rsp_t)),
    .DEPTH (RSPQ_DEPTH)
  ) u_rspq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rsp_push),
    .wdata (rsp),
    .full  (rsp_full),
    .pop   (out_pop),
    .rdata (out_rsp),
    .empty (out_empty)
  );

endmodule

@@ sv/rcct_fifo.sv @@
// ----------------------------------------------------------------------------
// rcct_fifo - small register queue
// Flop-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module rcct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rd_ptr_r];

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ sv/rcct_front.sv @@
// ----------------------------------------------------------------------------
// rcct_front - request intake and classification
// Accepts requests, sorts them into job classes and queues them for the back.
// ----------------------------------------------------------------------------
module rcct_front
  import rcct_pkg::*;
#(
  parameter int NODE_COUNT = 4096
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_push,
  input  in_req_t in_req,
  output logic    in_full,
  input  logic    job_pop,
  output job_t    job,
  output logic    job_empty
);

  logic [31:0] node_ext;
  logic        in_range;
  job_t        job_in;

  assign node_ext = 32'(in_req.node_index);
  assign in_range = (node_ext < 32'(NODE_COUNT));

  // Classify the request
  always_comb begin
    job_in.node_index     = in_req.node_index;
    job_in.occ_delta      = in_req.occ_delta;
    job_in.capacity_value = in_req.capacity_value;
    job_in.path_last      = in_req.path_last;
    if (!in_range) begin
      job_in.kind = JOB_NULL;
    end else begin
      unique case (in_req.cmd)
        CMD_LOAD:   job_in.kind = JOB_LOAD;
        CMD_UPDATE: job_in.kind = JOB_UPDATE;
        CMD_SWEEP:  job_in.kind = JOB_SWEEP;
        default:    job_in.kind = JOB_PEEK;
      endcase
    end
  end

  // Decoupling queue toward the back end
  rcct_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (job_in),
    .full  (in_full),
    .pop   (job_pop),
    .rdata (job),
    .empty (job_empty)
  );

endmodule

@@ sv/rcct_back.sv @@
// ----------------------------------------------------------------------------
// rcct_back - table read-modify-write engine
// Reads the node entry, updates occupancy and costs, writes back, emits result.
// ----------------------------------------------------------------------------
module rcct_back
  import rcct_pkg::*;
#(
  parameter int NODE_COUNT     = 4096,
  parameter int COST_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  job_t              job,
  input  logic              job_empty,
  output logic              job_pop,
  input  logic [COST_W-1:0] present_factor,
  input  logic [COST_W-1:0] history_factor,
  input  logic              out_full,
  output logic              out_push,
  output out_rsp_t          out_rsp
);

  localparam int ADDR_W = $clog2(NODE_COUNT);
  localparam logic [COST_W-1:0] COST_ONE = COST_W'(1) << COST_FRAC_BITS;

  typedef struct packed {
    logic [CAP_W-1:0]  cap;
    logic [OCC_W-1:0]  occ;
    logic [COST_W-1:0] pres;
    logic [COST_W-1:0] hist;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SUM
  } state_t;

  // Table storage
  entry_t mem [NODE_COUNT];

  state_t             state_r;
  job_t               cur_r;
  entry_t             rd_r;
  logic [OCC_W-1:0]   occ_n_r;
  status_t            occ_st_r;
  logic [PROD_W-1:0]  prod_p_r, prod_h_r;

  logic [31:0]        rd_node_ext, wr_node_ext;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic signed [11:0] occ_sum;
  logic [OCC_W-1:0]   occ_n;
  status_t            occ_st;
  logic [OVER_W-1:0]  over_p, over_h;
  logic [SUM_W-1:0]   pres_full, hist_full;
  logic               pres_sat, hist_sat;
  logic [COST_W-1:0]  pres_c, hist_c;
  entry_t             wr_entry;
  logic               mem_we;
  status_t            rsp_st;

  assign rd_node_ext = 32'(job.node_index);
  assign wr_node_ext = 32'(cur_r.node_index);
  assign rd_addr     = rd_node_ext[ADDR_W-1:0];
  assign wr_addr     = wr_node_ext[ADDR_W-1:0];

  assign job_pop = (state_r == ST_IDLE) && !job_empty && !out_full;

  // Occupancy update with clamping
  assign occ_sum = $signed({2'b00, rd_r.occ}) + 12'(cur_r.occ_delta);

  always_comb begin
    occ_n  = rd_r.occ;
    occ_st = ST_OK;
    if (cur_r.kind == JOB_UPDATE) begin
      priority if (occ_sum < 0) begin
        occ_n  = '0;
        occ_st = ST_OCC_ZERO;
      end else if (occ_sum > $signed(12'(OCC_MAX))) begin
        occ_n  = OCC_MAX;
        occ_st = ST_OCC_SAT;
      end else begin
        occ_n = occ_sum[OCC_W-1:0];
      end
    end
  end

  // Over-capacity counts; zero where no cost is added
  always_comb begin
    over_p = '0;
    over_h = '0;
    if (occ_n >= OCC_W'(rd_r.cap)) begin
      over_p = OVER_W'(occ_n) + 1'b1 - OVER_W'(rd_r.cap);
    end
    if (cur_r.kind == JOB_SWEEP && occ_n > OCC_W'(rd_r.cap)) begin
      over_h = OVER_W'(occ_n) - OVER_W'(rd_r.cap);
    end
  end

  // Cost sums with saturation
  assign pres_full = SUM_W'(COST_ONE) + SUM_W'(prod_p_r);
  assign hist_full = SUM_W'(rd_r.hist) + SUM_W'(prod_h_r);
  assign pres_sat  = (pres_full[SUM_W-1:COST_W] != '0);
  assign hist_sat  = (hist_full[SUM_W-1:COST_W] != '0);
  assign pres_c    = pres_sat ? COST_MAX : pres_full[COST_W-1:0];
  assign hist_c    = hist_sat ? COST_MAX : hist_full[COST_W-1:0];

  // Result and write-back entry
  always_comb begin
    wr_entry = rd_r;
    mem_we   = 1'b0;
    rsp_st   = ST_OK;
    unique case (cur_r.kind)
      JOB_LOAD: begin
        wr_entry.cap  = cur_r.capacity_value;
        wr_entry.occ  = '0;
        wr_entry.pres = COST_ONE;
        wr_entry.hist = COST_ONE;
        mem_we        = 1'b1;
      end
      JOB_UPDATE: begin
        wr_entry.occ  = occ_n_r;
        wr_entry.pres = pres_c;
        mem_we        = 1'b1;
        if (occ_st_r != ST_OK) begin
          rsp_st = occ_st_r;
        end else if (pres_sat) begin
          rsp_st = ST_COST_SAT;
        end
      end
      JOB_SWEEP: begin
        wr_entry.occ  = occ_n_r;
        wr_entry.pres = pres_c;
        wr_entry.hist = hist_c;
        mem_we        = 1'b1;
        if (pres_sat || hist_sat) begin
          rsp_st = ST_COST_SAT;
        end
      end
      JOB_PEEK: begin
        wr_entry = rd_r;
      end
      JOB_NULL: begin
        wr_entry = '0;
      end
      default: begin
        wr_entry = '0;
      end
    endcase
  end

  assign out_push             = (state_r == ST_SUM);
  assign out_rsp.out_node     = cur_r.node_index;
  assign out_rsp.occupancy    = wr_entry.occ;
  assign out_rsp.present_cost = wr_entry.pres;
  assign out_rsp.history_cost = wr_entry.hist;
  assign out_rsp.status       = rsp_st;
  assign out_rsp.out_last     = cur_r.path_last;

  // Sequencer: issue read, multiply, sum and write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (job_pop) begin
            cur_r   <= job;
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          occ_n_r  <= occ_n;
          occ_st_r <= occ_st;
          prod_p_r <= PROD_W'(over_p) * PROD_W'(present_factor);
          prod_h_r <= PROD_W'(over_h) * PROD_W'(history_factor);
          state_r  <= ST_SUM;
        end
        ST_SUM: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Table port: read at issue, write at the end of the job
  always_ff @(posedge clk) begin
    if (job_pop) begin
      rd_r <= mem[rd_addr];
    end
    if (out_push && mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Checks
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_calc_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> $past(job_pop))
    else $error("calculation without a job issue");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |=> !out_push)
    else $error("more than one result per job");

  a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && mem_we) |-> (cur_r.kind != JOB_NULL && cur_r.kind != JOB_PEEK))
    else $error("table written by a read-only job");

endmodule
